@@ design/pctd_pkg.sv @@
// shared types, phase encoding and hex helpers for the percent decoder
// depends on nothing; imported by every module of the block
package pctd_pkg;

   localparam logic [7:0] PCT_CHAR  = 8'h25;
   localparam int         MAX_UNITS = 4;
   localparam int         CNT_W     = $clog2(MAX_UNITS + 1);
   localparam int         IDX_W     = $clog2(MAX_UNITS);

   typedef enum logic [2:0] {
      PH_IDLE  = 3'd0,
      PH_PCT   = 3'd1,
      PH_HEX1  = 3'd2,
      PH_LEAD  = 3'd3,
      PH_LPCT  = 3'd4,
      PH_LHEX1 = 3'd5
   } phase_type;

   typedef struct packed {
      logic [7:0] text_byte;
      logic       end_of_text;
   } req_type;

   typedef struct packed {
      logic [15:0] code_unit;
      logic        run_last;
      logic        text_done;
   } rsp_type;

   // code units produced by one input beat
   typedef struct packed {
      logic [CNT_W-1:0]               count;
      logic [MAX_UNITS-1:0][15:0]     units;
      logic                           done;
   } burst_type;

   function automatic logic is_hex(input logic [7:0] c);
      return (c >= 8'h30 && c <= 8'h39) || (c >= 8'h41 && c <= 8'h46) ||
             (c >= 8'h61 && c <= 8'h66);
   endfunction

   function automatic logic [3:0] hex_val(input logic [7:0] c);
      logic [7:0] v;
      if (c >= 8'h41 && c <= 8'h46) begin
         v = c - 8'h37;
      end else if (c >= 8'h61 && c <= 8'h66) begin
         v = c - 8'h57;
      end else begin
         v = c;
      end
      return v[3:0];
   endfunction

endpackage

@@ design/pctd_decode.sv @@
// escape decoder: phase state machine and the code units of one input beat
// depends on pctd_pkg
module pctd_decode
   import pctd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      req_fire,
   input  req_type   req_data,
   output burst_type burst
);

   phase_type  phase_ff, phase_in, phase_step;
   logic [7:0] first_hex_ff, first_hex_in;
   logic [7:0] lead_ff, lead_in;
   logic [7:0] c;
   logic [7:0] hex_byte;
   logic       last;

   assign c        = req_data.text_byte;
   assign last     = req_data.end_of_text;
   assign hex_byte = {hex_val(first_hex_ff), hex_val(c)};

   // next state
   always_comb begin
      phase_step   = PH_IDLE;
      first_hex_in = first_hex_ff;
      lead_in      = lead_ff;
      unique case (phase_ff)
         PH_PCT: begin
            if (is_hex(c)) begin
               first_hex_in = c;
               phase_step   = PH_HEX1;
            end else begin
               phase_step = (c == PCT_CHAR) ? PH_PCT : PH_IDLE;
            end
         end
         PH_HEX1: begin
            if (is_hex(c)) begin
               if (hex_byte[7]) begin
                  lead_in    = hex_byte;
                  phase_step = PH_LEAD;
               end else begin
                  phase_step = PH_IDLE;
               end
            end else begin
               phase_step = (c == PCT_CHAR) ? PH_PCT : PH_IDLE;
            end
         end
         PH_LEAD: begin
            phase_step = (c == PCT_CHAR) ? PH_LPCT : PH_IDLE;
         end
         PH_LPCT: begin
            if (is_hex(c)) begin
               first_hex_in = c;
               phase_step   = PH_LHEX1;
            end else begin
               phase_step = (c == PCT_CHAR) ? PH_PCT : PH_IDLE;
            end
         end
         PH_LHEX1: begin
            if (is_hex(c)) begin
               phase_step = PH_IDLE;
            end else begin
               phase_step = (c == PCT_CHAR) ? PH_PCT : PH_IDLE;
            end
         end
         default: begin
            phase_step = (c == PCT_CHAR) ? PH_PCT : PH_IDLE;
         end
      endcase
      phase_in = last ? PH_IDLE : phase_step;
   end

   // outputs: list of code units for this beat
   always_comb begin
      logic [CNT_W-1:0]           n;
      logic [MAX_UNITS-1:0][15:0] u;
      logic                       feed;
      n    = '0;
      u    = '0;
      feed = 1'b0;
      unique case (phase_ff)
         PH_PCT: begin
            if (!is_hex(c)) begin
               u[n[IDX_W-1:0]] = {8'h00, PCT_CHAR};
               n    = n + 1'b1;
               feed = 1'b1;
            end
         end
         PH_HEX1: begin
            if (is_hex(c)) begin
               if (!hex_byte[7]) begin
                  u[n[IDX_W-1:0]] = {8'h00, hex_byte};
                  n = n + 1'b1;
               end
            end else begin
               u[n[IDX_W-1:0]] = {8'h00, PCT_CHAR};
               n = n + 1'b1;
               u[n[IDX_W-1:0]] = {8'h00, first_hex_ff};
               n    = n + 1'b1;
               feed = 1'b1;
            end
         end
         PH_LEAD: begin
            if (c != PCT_CHAR) begin
               u[n[IDX_W-1:0]] = {8'h00, lead_ff};
               n    = n + 1'b1;
               feed = 1'b1;
            end
         end
         PH_LPCT: begin
            if (!is_hex(c)) begin
               u[n[IDX_W-1:0]] = {8'h00, lead_ff};
               n = n + 1'b1;
               u[n[IDX_W-1:0]] = {8'h00, PCT_CHAR};
               n    = n + 1'b1;
               feed = 1'b1;
            end
         end
         PH_LHEX1: begin
            if (is_hex(c)) begin
               // two-byte utf-8 join
               u[n[IDX_W-1:0]] = {5'b00000, lead_ff[4:0], hex_byte[5:0]};
               n = n + 1'b1;
            end else begin
               u[n[IDX_W-1:0]] = {8'h00, lead_ff};
               n = n + 1'b1;
               u[n[IDX_W-1:0]] = {8'h00, PCT_CHAR};
               n = n + 1'b1;
               u[n[IDX_W-1:0]] = {8'h00, first_hex_ff};
               n    = n + 1'b1;
               feed = 1'b1;
            end
         end
         default: begin
            feed = 1'b1;
         end
      endcase
      if (feed && c != PCT_CHAR) begin
         u[n[IDX_W-1:0]] = {8'h00, c};
         n = n + 1'b1;
      end
      // flush whatever is still held at end of text
      if (last) begin
         unique case (phase_step)
            PH_PCT: begin
               u[n[IDX_W-1:0]] = {8'h00, PCT_CHAR};
               n = n + 1'b1;
            end
            PH_HEX1: begin
               u[n[IDX_W-1:0]] = {8'h00, PCT_CHAR};
               n = n + 1'b1;
               u[n[IDX_W-1:0]] = {8'h00, first_hex_in};
               n = n + 1'b1;
            end
            PH_LEAD: begin
               u[n[IDX_W-1:0]] = {8'h00, lead_in};
               n = n + 1'b1;
            end
            PH_LPCT: begin
               u[n[IDX_W-1:0]] = {8'h00, lead_in};
               n = n + 1'b1;
               u[n[IDX_W-1:0]] = {8'h00, PCT_CHAR};
               n = n + 1'b1;
            end
            PH_LHEX1: begin
               u[n[IDX_W-1:0]] = {8'h00, lead_in};
               n = n + 1'b1;
               u[n[IDX_W-1:0]] = {8'h00, PCT_CHAR};
               n = n + 1'b1;
               u[n[IDX_W-1:0]] = {8'h00, first_hex_in};
               n = n + 1'b1;
            end
            default: begin
            end
         endcase
      end
      burst.count = n;
      burst.units = u;
      burst.done  = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         first_hex_ff <= '0;
         lead_ff      <= '0;
      end else if (req_fire) begin
         phase_ff     <= phase_in;
         first_hex_ff <= first_hex_in;
         lead_ff      <= lead_in;
      end
   end

endmodule

@@ design/pctd_burst.sv @@
// result register: holds the code units of one beat and hands them out in order
// depends on pctd_pkg
module pctd_burst
   import pctd_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      load,
   input  burst_type burst,
   output logic      can_load,
   output logic      rsp_valid,
   input  logic      rsp_ready,
   output rsp_type   rsp_data
);

   logic [CNT_W-1:0]           remain_ff, remain_in;
   logic [IDX_W-1:0]           idx_ff, idx_in;
   logic [MAX_UNITS-1:0][15:0] units_ff, units_in;
   logic                       done_ff, done_in;
   logic                       take;

   assign rsp_valid = (remain_ff != '0);
   assign take      = rsp_valid && rsp_ready;
   assign can_load  = (remain_ff == '0) || (remain_ff == CNT_W'(1) && rsp_ready);

   assign rsp_data.code_unit = units_ff[idx_ff];
   assign rsp_data.run_last  = (remain_ff == CNT_W'(1));
   assign rsp_data.text_done = (remain_ff == CNT_W'(1)) && done_ff;

   always_comb begin
      remain_in = remain_ff;
      idx_in    = idx_ff;
      units_in  = units_ff;
      done_in   = done_ff;
      if (load) begin
         remain_in = burst.count;
         idx_in    = '0;
         units_in  = burst.units;
         done_in   = burst.done;
      end else if (take) begin
         remain_in = remain_ff - 1'b1;
         idx_in    = idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         idx_ff    <= '0;
      end else begin
         remain_ff <= remain_in;
         idx_ff    <= idx_in;
      end
      units_ff <= units_in;
      done_ff  <= done_in;
   end

   a_remain_bound: assert property (@(posedge clock) disable iff (reset)
      remain_ff <= CNT_W'(MAX_UNITS))
      else $error("burst count beyond maximum");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (remain_ff == '0 || (remain_ff == CNT_W'(1) && rsp_ready)))
      else $error("burst loaded over undelivered units");

   a_idx_advance: assert property (@(posedge clock) disable iff (reset)
      (take && !load && remain_ff > CNT_W'(1)) |=>
         (idx_ff == $past(idx_ff) + 1'b1 && remain_ff == $past(remain_ff) - 1'b1))
      else $error("burst index did not advance");

   a_done_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.text_done) |-> rsp_data.run_last)
      else $error("end of text marked on a non-final unit");

endmodule

@@ design/percent_decode_utf8_pair_top.sv @@
// top level of the url percent decoder with two-byte utf-8 joining
// depends on pctd_pkg, pctd_decode and pctd_burst
//
// Takes encoded url text one byte per req beat and returns 16-bit code units
// on rsp. Plain bytes pass through, %XX escapes decode to a byte, and a decoded
// byte of 0x80 or above followed by a second escape is joined into one utf-8
// code unit ((lead & 0x1f) << 6) | (trail & 0x3f). Malformed escapes and lone
// lead bytes are given back literally; end_of_text flushes anything held. Each
// accepted byte yields zero to four units; run_last marks the last unit of a
// byte and text_done the last unit of the text (no mark if the final byte
// yields nothing). Timing: the first unit of a byte appears in the cycle after
// the byte is accepted. While rsp_ready is high, bytes yielding at most one unit
// are taken at one byte per clock; a byte yielding two or more units holds the
// result register until all are taken, since that register hands out one unit per
// clock while rsp_ready is high, and the next byte is taken in the cycle its last
// unit is taken. Bursts of more than one unit only come from malformed escapes,
// lone lead bytes and flushes.
module percent_decode_utf8_pair_top
   import pctd_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   burst_type burst;
   logic      can_load;
   logic      req_fire;

   // take a new byte whenever the result register is empty or draining its last unit
   assign req_ready = can_load;
   assign req_fire  = req_valid && req_ready;

   // escape state machine, updates on each accepted beat
   pctd_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_fire (req_fire),
      .req_data (req_data),
      .burst    (burst)
   );

   // result register, one unit per rsp beat
   pctd_burst u_burst (
      .clock     (clock),
      .reset     (reset),
      .load      (req_fire),
      .burst     (burst),
      .can_load  (can_load),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule
